/* rtl/decimal_fixed_point_alu_top_macros.svh */
// Assertion macros for the decimal fixed-point ALU.
// They rely on i_clk and i_rst_n being visible where they are used.
`ifndef DECIMAL_FIXED_POINT_ALU_TOP_MACROS_SVH
`define DECIMAL_FIXED_POINT_ALU_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFPA_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dfpa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DFPA_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dfpa assertion failed");

`endif

/* rtl/dfpa_pkg.sv */
// Shared types, constants and helpers for the decimal fixed-point ALU.
// No dependencies.
package dfpa_pkg;

    localparam int MAG_W      = 54;
    localparam int HALF_W     = 27;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int DEF_DIGITS = 4;

    localparam logic [MAG_W-1:0] MAX_MAG = 54'd10000000000000000;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_LT  = 3'd4;
    localparam logic [2:0] MODE_GT  = 3'd5;
    localparam logic [2:0] MODE_EQ  = 3'd6;
    localparam logic [2:0] MODE_NEG = 3'd7;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_DIVZ = 2'd1;
    localparam logic [1:0] FAULT_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]       mode;
        logic [MAG_W-1:0] a_mag;
        logic             a_neg;
        logic [MAG_W-1:0] b_mag;
        logic             b_neg;
    } t_in;

    typedef struct packed {
        logic [MAG_W-1:0] res_mag;
        logic             res_neg;
        logic             compare_true;
        logic [1:0]       fault;
    } t_out;

    // Side information that travels alongside the datapath.
    typedef struct packed {
        logic md;
        logic neg;
        t_out res;
    } t_tag;

    // One classified item: x times y divided by d for multiply and divide.
    typedef struct packed {
        t_tag             tag;
        logic [MAG_W-1:0] x;
        logic [MAG_W-1:0] y;
        logic [MAG_W-1:0] d;
    } t_work;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic has_data;
        logic full;
    } t_qstat;

    // Ten to the power n, for n up to eight.
    function automatic logic [MAG_W-1:0] pow10(input int n);
        logic [MAG_W-1:0] p;
        p = {{(MAG_W-1){1'b0}}, 1'b1};
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                p = p * 54'd10;
            end
        end
        return p;
    endfunction

endpackage

/* rtl/decimal_fixed_point_alu_top.sv */
// Decimal fixed-point ALU, sign and magnitude scaled by ten to DECIMAL_DIGITS.
// Channels: i_in_valid/o_in_ready carry t_in, o_out_valid/i_out_ready carry t_out.
// Every mode passes through one pipeline of partial products, a wide sum and a
// restoring divider of 108 stages, so results leave in the order taken.
// Throughput: one transaction per cycle unless held; the divider is fully pipelined.
// A two-entry queue parts the front register from the back pipeline, so the
// front keeps taking transactions while the back is held.
// When i_out_ready is low and the last stage holds a result, the back pipeline
// holds as a whole; the front fills its queue and then drops o_in_ready.
// Reset (synchronous, active low) empties the queue and clears all valid bits;
// no clearing pass is needed.
// Divide by zero gives zero with fault one; magnitudes above ten to sixteen
// saturate with fault two.
// Depends on dfpa_pkg, dfpa_front, dfpa_queue, dfpa_back and the macros header.
`include "decimal_fixed_point_alu_top_macros.svh"
module decimal_fixed_point_alu_top import dfpa_pkg::*; #(
    parameter int DECIMAL_DIGITS = DEF_DIGITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_qstat w_qs;
    logic   w_push;
    logic   w_pop;
    t_work  w_fw;
    t_work  w_bw;

    dfpa_front #(
        .DECIMAL_DIGITS(DECIMAL_DIGITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in      (i_in),
        .i_qs      (w_qs),
        .o_push    (w_push),
        .o_work    (w_fw)
    );

    dfpa_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_work (w_fw),
        .i_pop  (w_pop),
        .o_qs   (w_qs),
        .o_work (w_bw)
    );

    dfpa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qs       (w_qs),
        .i_work     (w_bw),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // Result fields stay within their ranges and agree with the fault code.
    `DFPA_CHECK(a_mag_range, o_out_valid, o_out.res_mag <= MAX_MAG)
    `DFPA_CHECK(a_ovf_sat, o_out_valid && o_out.fault == FAULT_OVF, o_out.res_mag == MAX_MAG)
    `DFPA_CHECK(a_cmp_clean, o_out_valid && o_out.compare_true, o_out.res_mag == '0 && o_out.fault == FAULT_NONE)
    // A full queue that is not drained stays full.
    `DFPA_CHECK_NEXT(a_queue_hold, w_qs.full && !w_pop, w_qs.full)

endmodule

/* rtl/dfpa_front.sv */
// Front end: registers the incoming transaction, classifies it and works out
// the simple modes. Depends on dfpa_pkg.
module dfpa_front import dfpa_pkg::*; #(
    parameter int DECIMAL_DIGITS = DEF_DIGITS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_in    i_in,
    input  t_qstat i_qs,
    output logic   o_push,
    output t_work  o_work
);

    localparam logic [MAG_W-1:0] SCALE = pow10(DECIMAL_DIGITS);

    logic r_v;
    t_in  r_in;

    assign o_push     = r_v && !i_qs.full;
    assign o_in_ready = !r_v || !i_qs.full;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_in_ready) begin
            r_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Classification and the add, subtract, compare, negate and divide-by-zero results.
    always_comb begin
        logic [MAG_W:0]   m;
        logic [MAG_W:0]   sum;
        logic             bn;
        logic signed [MAG_W+1:0] sa;
        logic signed [MAG_W+1:0] sb;
        m   = '0;
        sum = {1'b0, r_in.a_mag} + {1'b0, r_in.b_mag};
        bn  = r_in.b_neg ^ (r_in.mode == MODE_SUB);
        sa  = r_in.a_neg ? -$signed({2'b00, r_in.a_mag}) : $signed({2'b00, r_in.a_mag});
        sb  = r_in.b_neg ? -$signed({2'b00, r_in.b_mag}) : $signed({2'b00, r_in.b_mag});
        o_work     = '0;
        o_work.x   = r_in.a_mag;
        o_work.y   = r_in.b_mag;
        o_work.d   = SCALE;
        o_work.tag.neg = r_in.a_neg ^ r_in.b_neg;
        unique case (r_in.mode) inside
            MODE_ADD, MODE_SUB: begin
                if (r_in.a_neg == bn) begin
                    m = sum;
                    o_work.tag.res.res_neg = r_in.a_neg;
                end else if (r_in.a_mag >= r_in.b_mag) begin
                    m = {1'b0, r_in.a_mag - r_in.b_mag};
                    o_work.tag.res.res_neg = r_in.a_neg;
                end else begin
                    m = {1'b0, r_in.b_mag - r_in.a_mag};
                    o_work.tag.res.res_neg = bn;
                end
                if (m == '0) begin
                    o_work.tag.res.res_neg = 1'b0;
                end
            end
            MODE_MUL: begin
                o_work.tag.md = 1'b1;
            end
            MODE_DIV: begin
                if (r_in.b_mag == '0) begin
                    o_work.tag.res.fault = FAULT_DIVZ;
                end else begin
                    o_work.tag.md = 1'b1;
                    o_work.y      = SCALE;
                    o_work.d      = r_in.b_mag;
                end
            end
            MODE_LT: o_work.tag.res.compare_true = (sa < sb);
            MODE_GT: o_work.tag.res.compare_true = (sa > sb);
            MODE_EQ: o_work.tag.res.compare_true = (sa == sb);
            default: begin
                m = {1'b0, r_in.a_mag};
                o_work.tag.res.res_neg = !r_in.a_neg;
            end
        endcase
        // Saturation of the simple results.
        if (m > {1'b0, MAX_MAG}) begin
            o_work.tag.res.res_mag = MAX_MAG;
            o_work.tag.res.fault   = FAULT_OVF;
        end else begin
            o_work.tag.res.res_mag = m[MAG_W-1:0];
        end
    end

endmodule

/* rtl/dfpa_queue.sv */
// Two-entry queue between the front end and the back end.
// Depends on dfpa_pkg.
module dfpa_queue import dfpa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_work  i_work,
    input  logic   i_pop,
    output t_qstat o_qs,
    output t_work  o_work
);

    t_work      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop       = i_pop && (r_cnt != 2'd0);
    assign o_qs.has_data = (r_cnt != 2'd0);
    assign o_qs.full     = (r_cnt == 2'd2);
    assign o_work        = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

endmodule

/* rtl/dfpa_back.sv */
// Back end: partial-product multiplier, wide sum and a bit-per-stage divider.
// Depends on dfpa_pkg.
module dfpa_back import dfpa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qstat i_qs,
    input  t_work  i_work,
    output logic   o_pop,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_out   o_out
);

    localparam int NDIV = PROD_W;
    localparam int NST  = NDIV + 2;

    logic             w_en;
    logic             r_vld [NST];
    t_tag             r_tag [NST];
    logic [MAG_W-1:0] r_ll, r_lh, r_hl, r_hh, r_d0;
    logic [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]  r_d1;
    logic [MAG_W:0]    w_mid;

    logic [MAG_W-1:0]  r_rem [NDIV];
    logic [PROD_W-1:0] r_dvd [NDIV];
    logic [MAG_W-1:0]  r_q   [NDIV];
    logic              r_st  [NDIV];
    logic [MAG_W-1:0]  r_dd  [NDIV];

    logic [MAG_W-1:0]  p_rem [NDIV];
    logic [PROD_W-1:0] p_dvd [NDIV];
    logic [MAG_W-1:0]  p_q   [NDIV];
    logic              p_st  [NDIV];
    logic [MAG_W-1:0]  p_dd  [NDIV];

    // The whole pipeline moves when its last stage is empty or taken.
    assign w_en        = !r_vld[NST-1] || i_out_ready;
    assign o_pop       = w_en;
    assign o_out_valid = r_vld[NST-1];

    // Valid bits and side information.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_qs.has_data;
            for (int i = 1; i < NST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tag[0] <= i_work.tag;
            for (int i = 1; i < NST; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    // Four 27 by 27 partial products.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ll <= i_work.x[HALF_W-1:0] * i_work.y[HALF_W-1:0];
            r_lh <= i_work.x[HALF_W-1:0] * i_work.y[MAG_W-1:HALF_W];
            r_hl <= i_work.x[MAG_W-1:HALF_W] * i_work.y[HALF_W-1:0];
            r_hh <= i_work.x[MAG_W-1:HALF_W] * i_work.y[MAG_W-1:HALF_W];
            r_d0 <= i_work.d;
        end
    end

    // Sum of the partial products into the full dividend.
    assign w_mid = {1'b0, r_lh} + {1'b0, r_hl};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= {r_hh, r_ll} + {{(PROD_W-MAG_W-1-HALF_W){1'b0}}, w_mid,
                                      {HALF_W{1'b0}}};
            r_d1   <= r_d0;
        end
    end

    // Restoring division, one quotient bit per stage.
    assign p_rem[0] = '0;
    assign p_dvd[0] = r_prod;
    assign p_q[0]   = '0;
    assign p_st[0]  = 1'b0;
    assign p_dd[0]  = r_d1;

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [MAG_W:0] w_t;
        logic [MAG_W:0] w_s;
        logic           w_ge;

        if (k > 0) begin : g_link
            assign p_rem[k] = r_rem[k-1];
            assign p_dvd[k] = r_dvd[k-1];
            assign p_q[k]   = r_q[k-1];
            assign p_st[k]  = r_st[k-1];
            assign p_dd[k]  = r_dd[k-1];
        end

        assign w_t  = {p_rem[k], p_dvd[k][PROD_W-1]};
        assign w_ge = (w_t >= {1'b0, p_dd[k]});
        assign w_s  = w_t - {1'b0, p_dd[k]};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[k] <= w_ge ? w_s[MAG_W-1:0] : w_t[MAG_W-1:0];
                r_dvd[k] <= {p_dvd[k][PROD_W-2:0], 1'b0};
                r_q[k]   <= {p_q[k][MAG_W-2:0], w_ge};
                r_st[k]  <= p_st[k] | p_q[k][MAG_W-1];
                r_dd[k]  <= p_dd[k];
            end
        end
    end

    // Final saturation and sign of the multiply and divide results.
    always_comb begin
        logic ovf;
        ovf   = r_st[NDIV-1] || (r_q[NDIV-1] > MAX_MAG);
        o_out = r_tag[NST-1].res;
        if (r_tag[NST-1].md) begin
            o_out.compare_true = 1'b0;
            o_out.res_mag      = ovf ? MAX_MAG : r_q[NDIV-1];
            o_out.fault        = ovf ? FAULT_OVF : FAULT_NONE;
            o_out.res_neg      = (!ovf && r_q[NDIV-1] == '0) ? 1'b0 : r_tag[NST-1].neg;
        end
    end

endmodule

/* dv/decimal_fixed_point_alu_top_tb.sv */
// Self-checking testbench for the decimal fixed-point ALU top level.
// It drives t_in transactions, predicts each t_out internally and compares them in order.
// Depends on dfpa_pkg and the decimal_fixed_point_alu_top RTL.
module decimal_fixed_point_alu_top_tb import dfpa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Ten to the power of the default digit count, used to rescale.
    localparam logic [127:0] SCALE = 128'd10000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    t_out expected_results[$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    decimal_fixed_point_alu_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always #5 i_clk = ~i_clk;

    // Compute the result that one input transaction should produce.
    function automatic t_out alu_result(t_in it);
        t_out r;
        logic [127:0] wide;
        logic [127:0] quo;
        logic [63:0] mag;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic rneg;
        logic bneg;
        r = '0;
        mag = '0;
        rneg = 1'b0;
        sa = it.a_neg ? -$signed({10'b0, it.a_mag}) : $signed({10'b0, it.a_mag});
        sb = it.b_neg ? -$signed({10'b0, it.b_mag}) : $signed({10'b0, it.b_mag});
        case (it.mode) inside
            MODE_ADD, MODE_SUB: begin
                bneg = (it.mode == MODE_SUB) ? ~it.b_neg : it.b_neg;
                if (it.a_neg == bneg) begin
                    mag = {10'b0, it.a_mag} + {10'b0, it.b_mag};
                    rneg = it.a_neg;
                end else if (it.a_mag >= it.b_mag) begin
                    mag = {10'b0, it.a_mag - it.b_mag};
                    rneg = it.a_neg;
                end else begin
                    mag = {10'b0, it.b_mag - it.a_mag};
                    rneg = bneg;
                end
            end
            MODE_MUL: begin
                wide = {74'b0, it.a_mag} * {74'b0, it.b_mag};
                quo = wide / SCALE;
                rneg = it.a_neg ^ it.b_neg;
                mag = (quo > {74'b0, MAX_MAG}) ? {10'b0, MAX_MAG} + 64'd1 : quo[63:0];
            end
            MODE_DIV: begin
                if (it.b_mag == '0) begin
                    r.fault = FAULT_DIVZ;
                end else begin
                    wide = {74'b0, it.a_mag} * SCALE;
                    quo = wide / {74'b0, it.b_mag};
                    rneg = it.a_neg ^ it.b_neg;
                    mag = (quo > {74'b0, MAX_MAG}) ? {10'b0, MAX_MAG} + 64'd1 : quo[63:0];
                end
            end
            MODE_LT: r.compare_true = (sa < sb);
            MODE_GT: r.compare_true = (sa > sb);
            MODE_EQ: r.compare_true = (sa == sb);
            default: begin
                mag = {10'b0, it.a_mag};
                rneg = ~it.a_neg;
            end
        endcase
        // Arithmetic zero is always positive; negate keeps a negative zero.
        if (it.mode <= MODE_DIV && r.fault == FAULT_NONE && mag == '0) begin
            rneg = 1'b0;
        end
        if (mag > {10'b0, MAX_MAG}) begin
            mag = {10'b0, MAX_MAG};
            r.fault = FAULT_OVF;
        end
        r.res_mag = mag[MAG_W-1:0];
        r.res_neg = rneg;
        return r;
    endfunction

    // Offer one transaction, idling first at random, and wait for its acceptance.
    task automatic send_item(t_in it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        expected_results.push_back(alu_result(it));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_op(logic [2:0] md, logic [MAG_W-1:0] am, logic an,
                           logic [MAG_W-1:0] bm, logic bn);
        t_in it;
        it.mode = md;
        it.a_mag = am;
        it.a_neg = an;
        it.b_mag = bm;
        it.b_neg = bn;
        send_item(it);
    endtask

    // Pick a magnitude from a spread of ranges, edges included.
    function automatic logic [MAG_W-1:0] rand_mag();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return MAG_W'($urandom_range(0, 200000));
            2: return MAG_W'($urandom);
            3: return MAX_MAG - MAG_W'($urandom_range(0, 20000));
            4: return MAX_MAG + MAG_W'($urandom_range(0, 3));
            5: return raw[MAG_W-1:0];
            6: return MAG_W'(raw % 64'd1000000000000);
            default: return MAG_W'(raw % (64'd1 << $urandom_range(1, 53)));
        endcase
    endfunction

    // Wait until every outstanding result has been checked.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Compare each accepted result with the oldest prediction; randomise ready.
    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transaction: %p", o_out);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_out.res_mag !== exp_res.res_mag || o_out.res_neg !== exp_res.res_neg
                    || o_out.compare_true !== exp_res.compare_true
                    || o_out.fault !== exp_res.fault) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p, got %p", exp_res, o_out);
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Edges of every mode, the zero sign rules, division by zero and saturation.
    task automatic test_directed();
        send_op(MODE_ADD, 54'd5, 1'b0, 54'd5, 1'b1);
        send_op(MODE_ADD, MAX_MAG, 1'b0, 54'd1, 1'b0);
        send_op(MODE_ADD, '1, 1'b1, '1, 1'b1);
        send_op(MODE_SUB, 54'd3, 1'b1, 54'd3, 1'b1);
        send_op(MODE_SUB, 54'd2, 1'b0, 54'd7, 1'b0);
        send_op(MODE_MUL, 54'd10000, 1'b1, 54'd25000, 1'b0);
        send_op(MODE_MUL, 54'd1, 1'b1, 54'd1, 1'b0);
        send_op(MODE_MUL, '1, 1'b0, '1, 1'b1);
        send_op(MODE_MUL, MAX_MAG, 1'b1, 54'd10000, 1'b1);
        send_op(MODE_DIV, 54'd70000, 1'b1, '0, 1'b1);
        send_op(MODE_DIV, 54'd10000, 1'b0, 54'd30000, 1'b1);
        send_op(MODE_DIV, MAX_MAG, 1'b0, 54'd1, 1'b0);
        send_op(MODE_DIV, '0, 1'b1, 54'd9, 1'b0);
        send_op(MODE_LT, '0, 1'b1, '0, 1'b0);
        send_op(MODE_LT, 54'd4, 1'b1, 54'd3, 1'b1);
        send_op(MODE_GT, '1, 1'b0, MAX_MAG, 1'b0);
        send_op(MODE_GT, 54'd4, 1'b1, 54'd3, 1'b1);
        send_op(MODE_EQ, '0, 1'b1, '0, 1'b0);
        send_op(MODE_EQ, 54'd8, 1'b1, 54'd8, 1'b0);
        send_op(MODE_NEG, '0, 1'b0, '1, 1'b1);
        send_op(MODE_NEG, '1, 1'b1, '0, 1'b0);
        send_op(MODE_NEG, MAX_MAG, 1'b0, '0, 1'b0);
        wait_for_drain();
    endtask

    // Random transactions under a given idling pattern on each side.
    task automatic test_random(int send_pct, int recv_pct, int count);
        t_in it;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            it.mode = 3'($urandom_range(0, 7));
            it.a_mag = rand_mag();
            it.a_neg = 1'($urandom);
            it.b_mag = ($urandom_range(0, 9) == 0) ? it.a_mag : rand_mag();
            it.b_neg = 1'($urandom);
            send_item(it);
            // Hold the sender off once mid-phase until the pipeline is empty.
            if (n == count / 2) wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(33, 87, 500);
        test_random(87, 33, 500);
        test_random(0, 0, 500);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("decimal_fixed_point_alu_top_tb: PASS");
        end else begin
            $display("decimal_fixed_point_alu_top_tb: FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5ms;
        $display("decimal_fixed_point_alu_top_tb: FAIL");
        $finish;
    end
endmodule
